// ----- design/rgtb_pkg.sv -----
// Shared types, codes and helper functions for the rotated glyph text blender.
package rgtb_pkg;

	// default sizes
	localparam int MAX_CHARS_DEF   = 8;
	localparam int GLYPH_W_DEF     = 16;
	localparam int GLYPH_H_DEF     = 20;
	localparam int GLYPH_COUNT_DEF = 95;
	localparam int DISP_W_DEF      = 240;
	localparam int DISP_H_DEF      = 320;

	// first printable character code
	localparam logic [7:0] FIRST_CODE = 8'd32;

	// item actions
	localparam logic [1:0] ACT_LOAD_WIDTH = 2'd0;
	localparam logic [1:0] ACT_LOAD_ALPHA = 2'd1;
	localparam logic [1:0] ACT_LOAD_CHAR  = 2'd2;
	localparam logic [1:0] ACT_RENDER     = 2'd3;

	// register indexes
	localparam logic [2:0] REG_COS        = 3'd0;
	localparam logic [2:0] REG_SIN        = 3'd1;
	localparam logic [2:0] REG_CENTER_X   = 3'd2;
	localparam logic [2:0] REG_CENTER_Y   = 3'd3;
	localparam logic [2:0] REG_TEXT_COLOR = 3'd4;
	localparam logic [2:0] REG_CHAR_COUNT = 3'd5;

	// register reset values
	localparam logic [15:0] COS_RESET   = 16'h4000;
	localparam logic [15:0] COLOR_RESET = 16'h39C7;

	localparam logic [7:0] ALPHA_FULL = 8'd255;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sum_acc;
		logic k_clr;
		logic prod;
		logic coord;
		logic srch_step;
		logic hit_cap;
		logic blend_mul;
		logic out_load;
		logic out_hit;
	} rgtb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_render;
		logic k_end;
		logic cand_ok;
		logic hit;
		logic out_free;
	} rgtb_stat_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	// exact x / 255 for x below 65535
	function automatic logic [15:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return 16'(t[16:8]);
	endfunction

endpackage

// ----- design/rotated_glyph_text_blender.sv -----
// Top level of the rotated anti-aliased text pixel renderer.
// Loads are written into their stores as they are accepted; the sequencer stays idle.
// A render runs a width-sum pass and, for a point in the text block, a search pass
// over the text store, each with a read and an accumulate or compare state per entry.
// The next item can be accepted in the cycle after its result is loaded; a held result
// waits in the output register. Reset (arst_n low, asynchronous) restores registers and
// idles the sequencer; glyph and text stores have no reset, undefined until written.
module rotated_glyph_text_blender #(
	parameter int MAX_CHARS   = rgtb_pkg::MAX_CHARS_DEF,
	parameter int GLYPH_W     = rgtb_pkg::GLYPH_W_DEF,
	parameter int GLYPH_H     = rgtb_pkg::GLYPH_H_DEF,
	parameter int GLYPH_COUNT = rgtb_pkg::GLYPH_COUNT_DEF,
	parameter int DISP_W      = rgtb_pkg::DISP_W_DEF,
	parameter int DISP_H      = rgtb_pkg::DISP_H_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [6:0]        glyph_index,
	input  logic [4:0]        glyph_row,
	input  logic [3:0]        glyph_col,
	input  logic [7:0]        load_value,
	input  logic [2:0]        char_pos,
	input  logic [7:0]        char_code,
	input  logic signed [8:0] offset_x,
	input  logic signed [8:0] offset_y,
	input  logic [15:0]       background,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_enable,
	output logic [7:0]        pixel_x,
	output logic [8:0]        pixel_y,
	output logic [15:0]       pixel_color
);
	import rgtb_pkg::*;

	rgtb_cmd_t  cmd;
	rgtb_stat_t st;

	assign cfg_ready = 1'b1;

	rgtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rgtb_dp #(
		.MAX_CHARS   (MAX_CHARS),
		.GLYPH_W     (GLYPH_W),
		.GLYPH_H     (GLYPH_H),
		.GLYPH_COUNT (GLYPH_COUNT),
		.DISP_W      (DISP_W),
		.DISP_H      (DISP_H)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.glyph_index  (glyph_index),
		.glyph_row    (glyph_row),
		.glyph_col    (glyph_col),
		.load_value   (load_value),
		.char_pos     (char_pos),
		.char_code    (char_code),
		.offset_x     (offset_x),
		.offset_y     (offset_y),
		.background   (background),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.write_enable (write_enable),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color)
	);

endmodule

// ----- design/rgtb_ctrl.sv -----
// Sequencer for loads and per-pixel render steps.
module rgtb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rgtb_pkg::rgtb_stat_t st,
	output rgtb_pkg::rgtb_cmd_t  cmd
);
	import rgtb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SUM_RD, S_SUM_ACC, S_PROD, S_COORD,
		S_SRCH_RD, S_SRCH_CMP, S_ALPHA, S_MUL, S_FIN, S_MISS
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	// commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:     cmd.accept = in_valid;
			S_SUM_ACC:  cmd.sum_acc = 1'b1;
			S_PROD: begin
				cmd.prod  = 1'b1;
				cmd.k_clr = 1'b1;
			end
			S_COORD:    cmd.coord = 1'b1;
			S_SRCH_CMP: begin
				cmd.hit_cap   = st.hit;
				cmd.srch_step = !st.hit;
			end
			S_MUL:      cmd.blend_mul = 1'b1;
			S_FIN: begin
				cmd.out_load = st.out_free;
				cmd.out_hit  = 1'b1;
			end
			S_MISS:     cmd.out_load = st.out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:     if (in_valid && st.in_render) state_q <= S_SUM_RD;
				S_SUM_RD:   state_q <= st.k_end ? S_PROD : S_SUM_ACC;
				S_SUM_ACC:  state_q <= S_SUM_RD;
				S_PROD:     state_q <= S_COORD;
				S_COORD:    state_q <= S_SRCH_RD;
				S_SRCH_RD:  state_q <= (!st.cand_ok || st.k_end) ? S_MISS : S_SRCH_CMP;
				S_SRCH_CMP: state_q <= st.hit ? S_ALPHA : S_SRCH_RD;
				S_ALPHA:    state_q <= S_MUL;
				S_MUL:      state_q <= S_FIN;
				S_FIN:      if (st.out_free) state_q <= S_IDLE;
				S_MISS:     if (st.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free) else $error("result loaded while output busy");

	// after a result is loaded the block takes new items again
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !in_stall) else $error("not idle after result");

endmodule

// ----- design/rgtb_dp.sv -----
// Datapath: registers, glyph stores, rotation, glyph search, blend and output register.
module rgtb_dp #(
	parameter int MAX_CHARS   = rgtb_pkg::MAX_CHARS_DEF,
	parameter int GLYPH_W     = rgtb_pkg::GLYPH_W_DEF,
	parameter int GLYPH_H     = rgtb_pkg::GLYPH_H_DEF,
	parameter int GLYPH_COUNT = rgtb_pkg::GLYPH_COUNT_DEF,
	parameter int DISP_W      = rgtb_pkg::DISP_W_DEF,
	parameter int DISP_H      = rgtb_pkg::DISP_H_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgtb_pkg::rgtb_cmd_t  cmd,
	output rgtb_pkg::rgtb_stat_t st,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [1:0]           action,
	input  logic [6:0]           glyph_index,
	input  logic [4:0]           glyph_row,
	input  logic [3:0]           glyph_col,
	input  logic [7:0]           load_value,
	input  logic [2:0]           char_pos,
	input  logic [7:0]           char_code,
	input  logic signed [8:0]    offset_x,
	input  logic signed [8:0]    offset_y,
	input  logic [15:0]          background,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 write_enable,
	output logic [7:0]           pixel_x,
	output logic [8:0]           pixel_y,
	output logic [15:0]          pixel_color
);
	import rgtb_pkg::*;

	localparam int GIW  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int RW   = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
	localparam int CW   = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
	localparam int PW   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int KW   = $clog2(MAX_CHARS + 1);
	localparam int WW   = $clog2(GLYPH_W + 1);
	localparam int TW   = $clog2(MAX_CHARS * GLYPH_W + 1);
	localparam int AD   = GLYPH_COUNT * GLYPH_H * GLYPH_W;
	localparam int AW   = (AD > 1) ? $clog2(AD) : 1;
	localparam int SXW  = TW + 13;

	// configuration registers
	logic signed [15:0] cos_q, sin_q;
	logic signed [9:0]  cx_q, cy_q;
	logic [15:0]        tcol_q;
	logic [3:0]         ccount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			tcol_q   <= COLOR_RESET;
			ccount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS:        cos_q    <= cfg_data;
				REG_SIN:        sin_q    <= cfg_data;
				REG_CENTER_X:   cx_q     <= cfg_data[9:0];
				REG_CENTER_Y:   cy_q     <= cfg_data[9:0];
				REG_TEXT_COLOR: tcol_q   <= cfg_data;
				REG_CHAR_COUNT: ccount_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// effective text length
	logic [KW-1:0] len;
	assign len = (6'(ccount_q) > 6'(MAX_CHARS)) ? KW'(MAX_CHARS) : KW'(ccount_q);

	// load decode
	logic ld_w, ld_a, ld_c;
	logic gi_ok, row_ok, col_ok, pos_ok;
	logic [WW-1:0] wsat;
	logic [AW-1:0] ld_addr;

	assign gi_ok  = {2'b0, glyph_index} < 9'(GLYPH_COUNT);
	assign row_ok = {2'b0, glyph_row} < 7'(GLYPH_H);
	assign col_ok = {3'b0, glyph_col} < 7'(GLYPH_W);
	assign pos_ok = {3'b0, char_pos} < 6'(MAX_CHARS);
	assign ld_w = cmd.accept && (action == ACT_LOAD_WIDTH) && gi_ok;
	assign ld_a = cmd.accept && (action == ACT_LOAD_ALPHA) && gi_ok && row_ok && col_ok;
	assign ld_c = cmd.accept && (action == ACT_LOAD_CHAR) && pos_ok;
	assign wsat = ({1'b0, load_value} > 9'(GLYPH_W)) ? WW'(GLYPH_W) : WW'(load_value);
	assign ld_addr = AW'((AW'(glyph_index) * AW'(GLYPH_H) + AW'(glyph_row)) * AW'(GLYPH_W)
		+ AW'(glyph_col));

	// stores
	logic [WW-1:0] wmem [GLYPH_COUNT];
	logic [7:0]    amem [AD];
	logic [7:0]    chars_q [MAX_CHARS];

	always_ff @(posedge clk) begin
		if (ld_c) chars_q[char_pos[PW-1:0]] <= char_code;
	end

	// character under the counter and its glyph number
	logic [KW-1:0] k_q;
	logic [7:0]    cur_code;
	logic [8:0]    gdiff;
	logic          cur_pr;
	assign cur_code = chars_q[k_q[PW-1:0]];
	assign gdiff    = {1'b0, cur_code} - {1'b0, FIRST_CODE};
	assign cur_pr   = (cur_code >= FIRST_CODE) && (gdiff < 9'(GLYPH_COUNT));

	// glyph width memory with registered read
	logic [WW-1:0]  wd_q;
	logic [GIW-1:0] gsel_q;
	logic           pr_q;
	always_ff @(posedge clk) begin
		if (ld_w) wmem[glyph_index[GIW-1:0]] <= wsat;
		wd_q   <= wmem[gdiff[GIW-1:0]];
		gsel_q <= gdiff[GIW-1:0];
		pr_q   <= cur_pr;
	end

	// glyph alpha memory with registered read
	logic [AW-1:0] addr_q;
	logic [7:0]    a_q;
	always_ff @(posedge clk) begin
		if (ld_a) amem[ld_addr] <= load_value;
		a_q <= amem[addr_q];
	end

	// render item capture
	logic signed [8:0]  ox_q, oy_q;
	logic [15:0]        bg_q;
	logic signed [10:0] px_w;
	logic signed [10:0] py_w;
	logic [7:0]         px_q;
	logic [8:0]         py_q;
	logic               onscr_q;
	assign px_w = {cx_q[9], cx_q} + {{2{offset_x[8]}}, offset_x};
	assign py_w = {cy_q[9], cy_q} + {{2{offset_y[8]}}, offset_y};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ox_q    <= offset_x;
			oy_q    <= offset_y;
			bg_q    <= background;
			px_q    <= px_w[7:0];
			py_q    <= py_w[8:0];
			onscr_q <= !px_w[10] && ({2'b0, px_w[9:0]} < 12'(DISP_W))
				&& !py_w[10] && ({2'b0, py_w[9:0]} < 12'(DISP_H));
		end
	end

	// counter, width sum and running start
	logic [TW-1:0] total_q, run_q;
	logic [TW:0]   run_end;
	logic [TW-1:0] sx_q;
	logic [RW-1:0] sy_q;
	logic          cand_q;
	logic          hit;
	assign run_end = {1'b0, run_q} + (TW + 1)'(wd_q);
	assign hit = pr_q && (sx_q >= run_q) && ({1'b0, sx_q} < run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			total_q <= '0;
			run_q   <= '0;
		end else begin
			if (cmd.accept || cmd.k_clr) k_q <= '0;
			else if (cmd.sum_acc || cmd.srch_step) k_q <= k_q + KW'(1);
			if (cmd.accept) total_q <= '0;
			else if (cmd.sum_acc && pr_q) total_q <= total_q + TW'(wd_q);
			if (cmd.accept) run_q <= '0;
			else if (cmd.srch_step && pr_q) run_q <= run_end[TW-1:0];
		end
	end

	// inverse rotation products
	logic signed [24:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			p_xc_q <= ox_q * cos_q;
			p_ys_q <= oy_q * sin_q;
			p_yc_q <= oy_q * cos_q;
			p_xs_q <= ox_q * sin_q;
		end
	end

	// sums, truncating divide by 2^14, and text block origin
	logic signed [25:0] sum_x, sum_y, bx, by;
	logic [11:0]        qx, qy;
	logic [SXW-1:0]     sx_w, sy_w;
	assign sum_x = {p_xc_q[24], p_xc_q} + {p_ys_q[24], p_ys_q};
	assign sum_y = {p_yc_q[24], p_yc_q} - {p_xs_q[24], p_xs_q};
	assign bx = sum_x + (sum_x[25] ? 26'sd16383 : 26'sd0);
	assign by = sum_y + (sum_y[25] ? 26'sd16383 : 26'sd0);
	assign qx = bx[25:14];
	assign qy = by[25:14];
	assign sx_w = {{(SXW - 12){qx[11]}}, qx} + SXW'(total_q >> 1);
	assign sy_w = {{(SXW - 12){qy[11]}}, qy} + SXW'(GLYPH_H / 2);

	always_ff @(posedge clk) begin
		if (cmd.coord) begin
			sx_q   <= sx_w[TW-1:0];
			sy_q   <= sy_w[RW-1:0];
			cand_q <= onscr_q && !sx_w[SXW-1] && (sx_w < SXW'(total_q))
				&& !sy_w[SXW-1] && (sy_w < SXW'(GLYPH_H));
		end
	end

	// alpha address of the hit
	logic [CW-1:0] local_x;
	assign local_x = CW'(sx_q - run_q);
	always_ff @(posedge clk) begin
		if (cmd.hit_cap)
			addr_q <= AW'((AW'(gsel_q) * AW'(GLYPH_H) + AW'(sy_q)) * AW'(GLYPH_W)
				+ AW'(local_x));
	end

	// per channel blend products
	logic [15:0] bg_un;
	logic [7:0]  inv_a;
	logic [15:0] mr_q, mg_q, mb_q;
	assign bg_un = swap16(bg_q);
	assign inv_a = ALPHA_FULL - a_q;
	always_ff @(posedge clk) begin
		if (cmd.blend_mul) begin
			mr_q <= 16'(tcol_q[15:11] * a_q) + 16'(bg_un[15:11] * inv_a);
			mg_q <= 16'(tcol_q[10:5] * a_q) + 16'(bg_un[10:5] * inv_a);
			mb_q <= 16'(tcol_q[4:0] * a_q) + 16'(bg_un[4:0] * inv_a);
		end
	end

	// result selection
	logic [15:0] dr, dg, db, mixed, res;
	logic        we;
	assign dr = div255(mr_q);
	assign dg = div255(mg_q);
	assign db = div255(mb_q);
	assign mixed = {dr[4:0], dg[5:0], db[4:0]};
	assign we  = cmd.out_hit && (a_q != 8'd0);
	assign res = (a_q == ALPHA_FULL) ? tcol_q : mixed;

	// output register
	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			write_enable <= we;
			pixel_x      <= onscr_q ? px_q : '0;
			pixel_y      <= onscr_q ? py_q : '0;
			pixel_color  <= we ? swap16(res) : bg_q;
		end
	end

	assign out_valid = ov_q;

	assign st.in_render = (action == ACT_RENDER);
	assign st.k_end     = (k_q == len);
	assign st.cand_ok   = cand_q;
	assign st.hit       = hit;
	assign st.out_free  = !ov_q || !out_stall;

	// width sum never runs past the text
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_acc |-> (k_q < len)) else $error("width sum past text end");

	// a hit is only taken for a point inside the text block
	a_hit_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_cap |-> cand_q) else $error("hit outside text block");

	// a written pixel is always on screen
	a_we_onscr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && we) |-> onscr_q) else $error("write off screen");

endmodule

// ----- tb/rgtb_checker.sv -----
// Transaction monitor, pixel predictor and scoreboard for the rotated glyph text blender.
module rgtb_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        action,
	input  logic [6:0]        glyph_index,
	input  logic [4:0]        glyph_row,
	input  logic [3:0]        glyph_col,
	input  logic [7:0]        load_value,
	input  logic [2:0]        char_pos,
	input  logic [7:0]        char_code,
	input  logic signed [8:0] offset_x,
	input  logic signed [8:0] offset_y,
	input  logic [15:0]       background,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              write_enable,
	input  logic [7:0]        pixel_x,
	input  logic [8:0]        pixel_y,
	input  logic [15:0]       pixel_color,
	output int                err_count,
	output int                pending,
	output int                n_pixels,
	output int                n_drawn
);
	import rgtb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GW = GLYPH_W_DEF;
	localparam int GH = GLYPH_H_DEF;
	localparam int GN = GLYPH_COUNT_DEF;
	localparam int MC = MAX_CHARS_DEF;

	typedef struct packed {
		logic        we;
		logic [7:0]  x;
		logic [8:0]  y;
		logic [15:0] color;
	} pixel_t;

	// mirrored block state
	int                width_mem [0:GN-1];
	logic [7:0]        alpha_mem [0:GN*GH*GW-1];
	logic [7:0]        text_mem  [0:MC-1];
	logic signed [15:0] cos_r, sin_r;
	logic signed [9:0]  cx_r, cy_r;
	logic [15:0]       color_r;
	logic [3:0]        count_r;

	pixel_t pixel_q [$];

	// one channel of the per-channel alpha blend
	function automatic int mix(input int fg, input int bg, input int a);
		return (fg * a + bg * (255 - a)) / 255;
	endfunction

	function automatic pixel_t predict_pixel(input logic signed [8:0] ox,
			input logic signed [8:0] oy, input logic [15:0] bgs);
		pixel_t r;
		int px, py, len, total, c, s, sx, sy, hit, loc, run, g, a;
		logic [15:0] bg, fg, res;
		r.we = 1'b0;
		r.x = '0;
		r.y = '0;
		r.color = bgs;
		px = int'(cx_r) + int'(ox);
		py = int'(cy_r) + int'(oy);
		if (px < 0 || px >= DISP_W_DEF || py < 0 || py >= DISP_H_DEF)
			return r;
		r.x = px[7:0];
		r.y = py[8:0];
		len = (count_r > MC) ? MC : int'(count_r);
		total = 0;
		for (int k = 0; k < len; k++) begin
			g = int'(text_mem[k]) - int'(FIRST_CODE);
			if (g >= 0 && g < GN)
				total += width_mem[g];
		end
		c = int'(cos_r);
		s = int'(sin_r);
		sx = (int'(ox) * c + int'(oy) * s) / 16384 + total / 2;
		sy = (int'(oy) * c - int'(ox) * s) / 16384 + GH / 2;
		if (sy < 0 || sy >= GH || sx < 0 || sx >= total)
			return r;
		// walk the text to find the glyph under the source point
		hit = -1;
		loc = 0;
		run = 0;
		for (int k = 0; k < len; k++) begin
			g = int'(text_mem[k]) - int'(FIRST_CODE);
			if (g < 0 || g >= GN)
				continue;
			if (hit < 0 && sx >= run && sx < run + width_mem[g]) begin
				hit = g;
				loc = sx - run;
			end
			run += width_mem[g];
		end
		if (hit < 0)
			return r;
		a = int'(alpha_mem[(hit * GH + sy) * GW + loc]);
		if (a == 0)
			return r;
		fg = color_r;
		if (a == int'(ALPHA_FULL)) begin
			res = fg;
		end else begin
			bg = {bgs[7:0], bgs[15:8]};
			res[15:11] = 5'(mix(int'(fg[15:11]), int'(bg[15:11]), a));
			res[10:5]  = 6'(mix(int'(fg[10:5]), int'(bg[10:5]), a));
			res[4:0]   = 5'(mix(int'(fg[4:0]), int'(bg[4:0]), a));
		end
		r.we = 1'b1;
		r.color = {res[7:0], res[15:8]};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			cos_r <= COS_RESET;
			sin_r <= '0;
			cx_r <= '0;
			cy_r <= '0;
			color_r <= COLOR_RESET;
			count_r <= '0;
			err_count = 0;
			n_pixels = 0;
			n_drawn = 0;
			pending <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COS:        cos_r <= cfg_data;
					REG_SIN:        sin_r <= cfg_data;
					REG_CENTER_X:   cx_r <= cfg_data[9:0];
					REG_CENTER_Y:   cy_r <= cfg_data[9:0];
					REG_TEXT_COLOR: color_r <= cfg_data;
					REG_CHAR_COUNT: count_r <= cfg_data[3:0];
					default: ;
				endcase
			end
			// result transaction against the oldest expectation
			if (out_valid && !out_stall) begin
				got = {write_enable, pixel_x, pixel_y, pixel_color};
				n_pixels++;
				if (write_enable) n_drawn++;
				if (pixel_q.size() == 0) begin
					err_count++;
					$display("%t: unexpected pixel we=%b x=%0d y=%0d color=%h", $realtime,
						write_enable, pixel_x, pixel_y, pixel_color);
				end else begin
					want = pixel_q.pop_front();
					if (got.we !== want.we) begin
						err_count++;
						$display("%t: write_enable expected %b actual %b", $realtime,
							want.we, got.we);
					end
					if (got.x !== want.x) begin
						err_count++;
						$display("%t: pixel_x expected %0d actual %0d", $realtime,
							want.x, got.x);
					end
					if (got.y !== want.y) begin
						err_count++;
						$display("%t: pixel_y expected %0d actual %0d", $realtime,
							want.y, got.y);
					end
					if (got.color !== want.color) begin
						err_count++;
						$display("%t: pixel_color expected %h actual %h", $realtime,
							want.color, got.color);
					end
				end
			end
			// input transaction: update stores or predict a pixel
			if (in_valid && !in_stall) begin
				case (action)
					ACT_LOAD_WIDTH:
						if (glyph_index < GN)
							width_mem[glyph_index] = (load_value > GW) ? GW : int'(load_value);
					ACT_LOAD_ALPHA:
						if (glyph_index < GN && glyph_row < GH && glyph_col < GW)
							alpha_mem[(int'(glyph_index) * GH + int'(glyph_row)) * GW
								+ int'(glyph_col)] = load_value;
					ACT_LOAD_CHAR:
						if (char_pos < MC)
							text_mem[char_pos] = char_code;
					default:
						pixel_q.push_back(predict_pixel(offset_x, offset_y, background));
				endcase
			end
			pending <= pixel_q.size();
		end
	end

endmodule

// ----- tb/tb_rotated_glyph_text_blender.sv -----
// Stimulus, clocking and verdict for the rotated glyph text blender testbench.
module tb_rotated_glyph_text_blender;
	import rgtb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]        act;
		logic [6:0]        gi;
		logic [4:0]        row;
		logic [3:0]        col;
		logic [7:0]        val;
		logic [2:0]        pos;
		logic [7:0]        code;
		logic signed [8:0] ox;
		logic signed [8:0] oy;
		logic [15:0]       bg;
	} item_t;

	typedef struct {
		logic [15:0] cs, sn, cx, cy, color, count;
	} setting_t;

	// glyphs that get nonzero widths; their alpha is loaded in full
	localparam int LIVE_N = 3;
	localparam logic [6:0] LIVE_GLYPH [LIVE_N] = '{7'd0, 7'd33, 7'd94};
	localparam int DRAIN = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [1:0] action = '0;
	logic [6:0] glyph_index = '0;
	logic [4:0] glyph_row = '0;
	logic [3:0] glyph_col = '0;
	logic [7:0] load_value = '0;
	logic [2:0] char_pos = '0;
	logic [7:0] char_code = '0;
	logic signed [8:0] offset_x = '0;
	logic signed [8:0] offset_y = '0;
	logic [15:0] background = '0;
	logic out_stall = 1'b0;
	logic cfg_ready, in_stall, out_valid, write_enable;
	logic [7:0] pixel_x;
	logic [8:0] pixel_y;
	logic [15:0] pixel_color;
	int err_count, pending, n_pixels, n_drawn;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	rotated_glyph_text_blender uut (.*);

	rgtb_checker scoreboard (.*);

	always #6 clk = ~clk;

	// result side back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		glyph_index <= it.gi;
		glyph_row <= it.row;
		glyph_col <= it.col;
		load_value <= it.val;
		char_pos <= it.pos;
		char_code <= it.code;
		offset_x <= it.ox;
		offset_y <= it.oy;
		background <= it.bg;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// let the block go quiet before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic item_t noise_item();
		item_t it;
		it = item_t'(($bits(item_t))'({$urandom, $urandom, $urandom}));
		return it;
	endfunction

	function automatic logic [7:0] alpha_byte();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return ALPHA_FULL;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic item_t render_item(input int ox, input int oy);
		item_t it;
		it = noise_item();
		it.act = ACT_RENDER;
		it.ox = 9'(ox);
		it.oy = 9'(oy);
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		it = noise_item();
		pick = $urandom_range(99);
		if (pick < 55) begin
			it.act = ACT_RENDER;
			if ($urandom_range(3) != 0) begin
				it.ox = 9'($urandom_range(140) - 70);
				it.oy = 9'($urandom_range(30) - 15);
			end
		end else if (pick < 72) begin
			it.act = ACT_LOAD_ALPHA;
			it.val = alpha_byte();
		end else if (pick < 84) begin
			// widths stay zero except on the fully loaded glyphs
			it.act = ACT_LOAD_WIDTH;
			case ($urandom_range(3))
				0: it.gi = 7'($urandom_range(127, GLYPH_COUNT_DEF));
				1: it.val = 8'd0;
				default: it.gi = LIVE_GLYPH[$urandom_range(LIVE_N - 1)];
			endcase
			if (it.gi < GLYPH_COUNT_DEF && it.val != 0) begin
				it.gi = LIVE_GLYPH[$urandom_range(LIVE_N - 1)];
				if ($urandom_range(1)) it.val = 8'($urandom_range(12));
			end
		end else begin
			it.act = ACT_LOAD_CHAR;
			if ($urandom_range(2) != 0)
				it.code = 8'(LIVE_GLYPH[$urandom_range(LIVE_N - 1)]) + FIRST_CODE;
		end
		return it;
	endfunction

	initial begin
		item_t it;
		setting_t phases [8];
		logic [7:0] text_init [8];
		int per_phase;
		phases[0] = '{16'd16384, 16'd0, 16'd120, 16'd160, 16'hFFFF, 16'd8};
		phases[1] = '{-16'sd16384, 16'd0, 16'd120, 16'd160, 16'h0000, 16'd15};
		phases[2] = '{16'd0, 16'd16384, 16'd100, 16'd200, 16'($urandom), 16'd5};
		phases[3] = '{16'd0, -16'sd16384, -16'sd512, 16'd511, 16'hF81F, 16'd8};
		phases[4] = '{16'd11585, 16'd11585, 16'd120, 16'd160, 16'($urandom), 16'd8};
		phases[5] = '{16'd14189, -16'sd8192, 16'd60, 16'd300, 16'($urandom), 16'd3};
		phases[6] = '{-16'sd11585, 16'd11585, 16'd511, -16'sd512, 16'($urandom), 16'd0};
		phases[7] = '{16'd16384, 16'd0, 16'd120, 16'd160, 16'($urandom), 16'd8};
		text_init = '{8'd65, 8'd32, 8'd31, 8'd97, 8'd126, 8'd127, 8'd0, 8'd255};
		per_phase = 52;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: empty text, centre at the screen corner
		send_item(render_item(0, 0));
		send_item(render_item(-1, 5));

		// fill widths, alpha of the live glyphs and the text store
		for (int g = 0; g < GLYPH_COUNT_DEF; g++) begin
			it = noise_item();
			it.act = ACT_LOAD_WIDTH;
			it.gi = 7'(g);
			it.val = 8'd0;
			send_item(it);
		end
		foreach (LIVE_GLYPH[i]) begin
			it = noise_item();
			it.act = ACT_LOAD_WIDTH;
			it.gi = LIVE_GLYPH[i];
			it.val = (i == 0) ? 8'd255 : (i == 1) ? 8'd7 : 8'd17;
			send_item(it);
			for (int r = 0; r < GLYPH_H_DEF; r++)
				for (int c = 0; c < GLYPH_W_DEF; c++) begin
					it = noise_item();
					it.act = ACT_LOAD_ALPHA;
					it.gi = LIVE_GLYPH[i];
					it.row = 5'(r);
					it.col = 4'(c);
					it.val = alpha_byte();
					send_item(it);
				end
		end
		foreach (text_init[p]) begin
			it = noise_item();
			it.act = ACT_LOAD_CHAR;
			it.pos = 3'(p);
			it.code = text_init[p];
			send_item(it);
		end

		// loads that fall outside the stores and must be dropped
		it = noise_item();
		it.act = ACT_LOAD_ALPHA;
		it.gi = 7'd127;
		it.row = 5'd31;
		it.col = 4'd15;
		send_item(it);
		it.gi = 7'd33;
		it.row = 5'd20;
		send_item(it);
		it = noise_item();
		it.act = ACT_LOAD_WIDTH;
		it.gi = 7'd95;
		it.val = 8'd9;
		send_item(it);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(REG_COS, phases[ph].cs);
			write_reg(REG_SIN, phases[ph].sn);
			write_reg(REG_CENTER_X, phases[ph].cx);
			write_reg(REG_CENTER_Y, phases[ph].cy);
			write_reg(REG_TEXT_COLOR, phases[ph].color);
			write_reg(REG_CHAR_COUNT, phases[ph].count);
			send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 85 : 0;
			recv_stall_pct = (ph < 3) ? 85 : (ph < 6) ? 8 : 0;
			if (ph == 0) begin
				// offset extremes, screen edges and the text centre
				send_item(render_item(0, 0));
				send_item(render_item(-256, -256));
				send_item(render_item(255, 255));
				send_item(render_item(-120, -160));
				send_item(render_item(119, 159));
				send_item(render_item(-121, 0));
				send_item(render_item(3, -9));
				send_item(render_item(-20, 4));
				send_item(render_item(30, -1));
			end
			for (int n = 0; n < per_phase; n++)
				send_item(random_item());
		end

		settle();
		$display("Covered %0d pixel results (%0d drawn) over 8 register settings,",
			n_pixels, n_drawn);
		$display("with stalls on either side and full-rate streaming.");
		if (err_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#15ms;
		$display("Timeout waiting for the block");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
